[hw/rtl/csmh_pkg.sv]
// ----------------------------------------------------------------------------
// csmh_pkg: shared constants and types for the cuboid stacking block
// Defaults for the block parameters, result widths and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package csmh_pkg;

  localparam int DEF_MAX_BOXES = 128;
  localparam int DEF_DIM_BITS  = 10;

  localparam int HEIGHT_BITS = 17;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = '1;

  // Commands from the controller, one pulse per action
  typedef struct packed {
    logic in_take;    // capture sorted cuboid and last flag
    logic ins_start;  // open insertion at the end of the store
    logic ins_shift;  // move one entry up, step down
    logic ins_put;    // write the new cuboid at the current slot
    logic drop;       // store full: mark overflow
    logic dp_ldi;     // fetch cuboid i
    logic dp_geti;    // latch cuboid i, start scan of earlier entries
    logic dp_scan;    // test one earlier entry
    logic dp_wr;      // store height of cuboid i, update best
    logic emit;       // load result register, open a new data set
  } csmh_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic last_q;
    logic shift_gt;   // fetched entry is greater than the new cuboid
    logic pos_one;
    logic i_zero;
    logic j_last;
    logic i_last;
    logic out_free;
  } csmh_sts_t;

endpackage

[hw/rtl/csmh_box_if.sv]
// ----------------------------------------------------------------------------
// csmh_box_if: input channel of the cuboid stacking block
// One item is one cuboid: edge lengths dim_a, dim_b, dim_c and a last flag.
// ----------------------------------------------------------------------------
interface csmh_box_if import csmh_pkg::*; #(
  parameter int DIM_BITS = DEF_DIM_BITS
) ();
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] dim_a;
  logic [DIM_BITS-1:0] dim_b;
  logic [DIM_BITS-1:0] dim_c;
  logic                last;

  modport source (output valid, dim_a, dim_b, dim_c, last, input ready);
  modport sink (input valid, dim_a, dim_b, dim_c, last, output ready);
endinterface

[hw/rtl/csmh_res_if.sv]
// ----------------------------------------------------------------------------
// csmh_res_if: result channel of the cuboid stacking block
// One item per data set: best stack height and overflow flag.
// ----------------------------------------------------------------------------
interface csmh_res_if import csmh_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [HEIGHT_BITS-1:0] max_height;
  logic                   overflow;

  modport source (output valid, max_height, overflow, input ready);
  modport sink (input valid, max_height, overflow, output ready);
endinterface

[hw/rtl/csmh_ctrl.sv]
// ----------------------------------------------------------------------------
// csmh_ctrl: controller of the cuboid stacking block
// Sequences sorted insertion into the store and the stacking scan.
// ----------------------------------------------------------------------------
module csmh_ctrl import csmh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  csmh_sts_t sts,
  output csmh_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_INS   = 9'b000000010,
    S_SHIFT = 9'b000000100,
    S_PUT   = 9'b000001000,
    S_DPI   = 9'b000010000,
    S_DPG   = 9'b000100000,
    S_DPS   = 9'b001000000,
    S_DPW   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state, state_next;
  state_t ins_done;

  assign in_ready = (state == S_IDLE);
  assign ins_done = sts.last_q ? S_DPI : S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_take = 1'b1;
          state_next  = S_INS;
        end
      end
      S_INS: begin
        if (sts.full) begin
          cmd.drop   = 1'b1;
          state_next = ins_done;
        end else begin
          cmd.ins_start = 1'b1;
          state_next    = sts.count_zero ? S_PUT : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.shift_gt) begin
          cmd.ins_shift = 1'b1;
          if (sts.pos_one) state_next = S_PUT;
        end else begin
          cmd.ins_put = 1'b1;
          state_next  = ins_done;
        end
      end
      S_PUT: begin
        cmd.ins_put = 1'b1;
        state_next  = ins_done;
      end
      S_DPI: begin
        cmd.dp_ldi = 1'b1;
        state_next = S_DPG;
      end
      S_DPG: begin
        cmd.dp_geti = 1'b1;
        state_next  = sts.i_zero ? S_DPW : S_DPS;
      end
      S_DPS: begin
        cmd.dp_scan = 1'b1;
        if (sts.j_last) state_next = S_DPW;
      end
      S_DPW: begin
        cmd.dp_wr  = 1'b1;
        state_next = sts.i_last ? S_EMIT : S_DPI;
      end
      S_EMIT: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

[hw/rtl/csmh_dp.sv]
// ----------------------------------------------------------------------------
// csmh_dp: datapath of the cuboid stacking block
// Edge sorter, sorted cuboid store, height table, scan registers and the
// result register.
// ----------------------------------------------------------------------------
module csmh_dp import csmh_pkg::*; #(
  parameter int MAX_BOXES = DEF_MAX_BOXES,
  parameter int DIM_BITS  = DEF_DIM_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  csmh_cmd_t              cmd,
  output csmh_sts_t              sts,
  input  logic [DIM_BITS-1:0]    dim_a,
  input  logic [DIM_BITS-1:0]    dim_b,
  input  logic [DIM_BITS-1:0]    dim_c,
  input  logic                   last,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [HEIGHT_BITS-1:0] max_height,
  output logic                   overflow
);

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int KEY_W = 3 * DIM_BITS;
  localparam int SUM_W = HEIGHT_BITS + 1;

  logic [KEY_W-1:0]       box_mem [MAX_BOXES];
  logic [HEIGHT_BITS-1:0] ht_mem  [MAX_BOXES];

  logic [KEY_W-1:0]       key;
  logic                   last_q;
  logic [CNT_W-1:0]       count;
  logic                   dropped;
  logic [IDX_W-1:0]       pos;
  logic [IDX_W-1:0]       i;
  logic [IDX_W-1:0]       j;
  logic [KEY_W-1:0]       ki;
  logic [HEIGHT_BITS-1:0] h;
  logic [HEIGHT_BITS-1:0] best;
  logic [KEY_W-1:0]       box_rd;
  logic [HEIGHT_BITS-1:0] ht_rd;

  logic [DIM_BITS-1:0]    lo1, hi1, mid2, top2, min3, mid3;
  logic [IDX_W-1:0]       rd_addr;
  logic                   box_we;
  logic [KEY_W-1:0]       box_wdata;
  logic [DIM_BITS-1:0]    ki_top;
  logic                   dominated;
  logic [SUM_W-1:0]       cand;
  logic [HEIGHT_BITS-1:0] cand_sat;

  // three compare-exchange steps put the edges in ascending order
  always_comb begin
    lo1  = (dim_a > dim_b) ? dim_b : dim_a;
    hi1  = (dim_a > dim_b) ? dim_a : dim_b;
    mid2 = (hi1 > dim_c) ? dim_c : hi1;
    top2 = (hi1 > dim_c) ? hi1 : dim_c;
    min3 = (lo1 > mid2) ? mid2 : lo1;
    mid3 = (lo1 > mid2) ? lo1 : mid2;
  end

  always_comb begin
    rd_addr = '0;
    if (cmd.ins_start)    rd_addr = IDX_W'(count - CNT_W'(1));
    else if (cmd.ins_shift) rd_addr = pos - IDX_W'(2);
    else if (cmd.dp_ldi)  rd_addr = i;
    else if (cmd.dp_scan) rd_addr = j + IDX_W'(1);
  end

  assign box_we    = cmd.ins_shift | cmd.ins_put;
  assign box_wdata = cmd.ins_shift ? box_rd : key;

  always_ff @(posedge clk) begin
    if (box_we) box_mem[pos] <= box_wdata;
    box_rd <= box_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.dp_wr) ht_mem[i] <= h;
    ht_rd <= ht_mem[rd_addr];
  end

  // dominance test of fetched entry j against cuboid i
  assign ki_top    = ki[DIM_BITS-1:0];
  assign dominated = (box_rd[KEY_W-1 -: DIM_BITS] <= ki[KEY_W-1 -: DIM_BITS]) &&
                     (box_rd[2*DIM_BITS-1 -: DIM_BITS] <= ki[2*DIM_BITS-1 -: DIM_BITS]) &&
                     (box_rd[DIM_BITS-1:0] <= ki_top);
  assign cand      = {1'b0, ht_rd} + SUM_W'(ki_top);
  assign cand_sat  = cand[SUM_W-1] ? HEIGHT_MAX : cand[HEIGHT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      key    <= {min3, mid3, top2};
      last_q <= last;
      i      <= '0;
      best   <= '0;
    end
    if (cmd.ins_start) pos <= IDX_W'(count);
    if (cmd.ins_shift) pos <= pos - IDX_W'(1);
    if (cmd.dp_geti) begin
      ki <= box_rd;
      h  <= HEIGHT_BITS'(box_rd[DIM_BITS-1:0]);
      j  <= '0;
    end
    if (cmd.dp_scan) begin
      j <= j + IDX_W'(1);
      if (dominated && (cand_sat > h)) h <= cand_sat;
    end
    if (cmd.dp_wr) begin
      i <= i + IDX_W'(1);
      if (h > best) best <= h;
    end
    if (cmd.emit) begin
      max_height <= best;
      overflow   <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ins_put) count <= count + CNT_W'(1);
      if (cmd.drop)    dropped <= 1'b1;
      if (cmd.emit) begin
        // open a new data set
        count     <= '0;
        dropped   <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.count_zero = (count == '0);
    sts.full       = (count == CNT_W'(MAX_BOXES));
    sts.last_q     = last_q;
    sts.shift_gt   = (box_rd > key);
    sts.pos_one    = (pos == IDX_W'(1));
    sts.i_zero     = (i == '0);
    sts.j_last     = ((j + IDX_W'(1)) == i);
    sts.i_last     = ((CNT_W'(i) + CNT_W'(1)) == count);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

[hw/rtl/cuboid_stack_max_height.sv]
// ----------------------------------------------------------------------------
// cuboid_stack_max_height: tallest stack of rotatable cuboids
// Takes cuboids on the boxes channel, keeps them sorted and, on the cuboid
// flagged last, runs the stacking scan and sends one item on result.
//
// boxes carries edges dim_a to dim_c and a last flag; an item is taken when
// valid and ready are both high. ready is high only while the block is idle.
// Each cuboid is sorted as it is taken and inserted into the store by
// moving larger entries up one slot per cycle. Cuboids beyond MAX_BOXES
// are dropped and reported through overflow.
// On the last cuboid the scan visits each stored cuboid i and all entries
// below it, one entry per cycle, then the result is loaded into the output
// register. result holds max_height and overflow until taken; a stalled
// receiver holds the block only when the next data set is ready to emit.
// Reset empties the store, clears the overflow mark and drops any pending
// result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cuboid_stack_max_height import csmh_pkg::*; #(
  parameter int MAX_BOXES = DEF_MAX_BOXES,
  parameter int DIM_BITS  = DEF_DIM_BITS
) (
  input logic        clk,
  input logic        rst,
  csmh_box_if.sink   boxes,
  csmh_res_if.source result
);

  csmh_cmd_t cmd;
  csmh_sts_t sts;

  csmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (boxes.valid),
    .in_ready (boxes.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csmh_dp #(
    .MAX_BOXES (MAX_BOXES),
    .DIM_BITS  (DIM_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .dim_a      (boxes.dim_a),
    .dim_b      (boxes.dim_b),
    .dim_c      (boxes.dim_c),
    .last       (boxes.last),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .max_height (result.max_height),
    .overflow   (result.overflow)
  );

endmodule

[tb/csmh_stack_checker.sv]
// ----------------------------------------------------------------------------
// csmh_stack_checker: result checker for the cuboid stacking block
// Watches both channels. Each accepted cuboid is sorted and inserted into a
// local ordered store. On the cuboid flagged last, the tallest stack is
// computed and queued. Each accepted result is compared field by field with
// the oldest queued result, and mismatches are counted.
// ----------------------------------------------------------------------------
module csmh_stack_checker import csmh_pkg::*; #(
  parameter int MAX_BOXES = DEF_MAX_BOXES,
  parameter int DIM_BITS  = DEF_DIM_BITS
) (
  input  logic clk,
  input  logic rst,
  csmh_box_if  boxes,
  csmh_res_if  result,
  output int   pending,
  output int   errors
);

  typedef struct packed {
    logic [DIM_BITS-1:0] lo;
    logic [DIM_BITS-1:0] mid;
    logic [DIM_BITS-1:0] hi;
  } cuboid_t;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] max_height;
    logic                   overflow;
  } stack_result_t;

  cuboid_t       sorted_boxes [MAX_BOXES];
  int            held_boxes;
  logic          boxes_dropped;
  stack_result_t heights_due [$];
  stack_result_t got;
  stack_result_t want;

  function automatic cuboid_t sort_edges(input logic [DIM_BITS-1:0] a, b, c);
    logic [DIM_BITS-1:0] t;
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (b > c) begin
      t = b; b = c; c = t;
    end
    if (a > b) begin
      t = a; a = b; b = t;
    end
    return '{lo: a, mid: b, hi: c};
  endfunction

  // Insert in lexicographic order; equal cuboids go after the ones held
  function automatic void store_box(input cuboid_t key);
    int slot;
    if (held_boxes < MAX_BOXES) begin
      slot = held_boxes;
      while (slot > 0 && sorted_boxes[slot-1] > key) begin
        sorted_boxes[slot] = sorted_boxes[slot-1];
        slot--;
      end
      sorted_boxes[slot] = key;
      held_boxes++;
    end else begin
      boxes_dropped = 1'b1;
    end
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] tallest_stack();
    int unsigned best_on [MAX_BOXES];
    int unsigned best;
    int unsigned h;
    int unsigned cand;
    best = 0;
    for (int i = 0; i < held_boxes; i++) begin
      h = 32'(sorted_boxes[i].hi);
      for (int j = 0; j < i; j++) begin
        if (sorted_boxes[j].lo <= sorted_boxes[i].lo &&
            sorted_boxes[j].mid <= sorted_boxes[i].mid &&
            sorted_boxes[j].hi <= sorted_boxes[i].hi) begin
          cand = best_on[j] + 32'(sorted_boxes[i].hi);
          if (cand > 32'(HEIGHT_MAX)) cand = 32'(HEIGHT_MAX);
          if (cand > h) h = cand;
        end
      end
      best_on[i] = h;
      if (h > best) best = h;
    end
    return best[HEIGHT_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_boxes = 0;
      boxes_dropped = 1'b0;
      heights_due.delete();
      pending = 0;
    end else begin
      if (result.valid && result.ready) begin
        got = '{max_height: result.max_height, overflow: result.overflow};
        if (heights_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: max_height %0d overflow %0b",
                   $time, got.max_height, got.overflow);
        end else begin
          want = heights_due.pop_front();
          if (got.max_height !== want.max_height) begin
            errors++;
            $display("%0t: max_height mismatch: expected %0d, got %0d",
                     $time, want.max_height, got.max_height);
          end
          if (got.overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow mismatch: expected %0b, got %0b",
                     $time, want.overflow, got.overflow);
          end
        end
      end
      if (boxes.valid && boxes.ready) begin
        store_box(sort_edges(boxes.dim_a, boxes.dim_b, boxes.dim_c));
        if (boxes.last) begin
          heights_due.push_back(stack_result_t'{max_height: tallest_stack(),
                                                overflow: boxes_dropped});
          // open a new data set
          held_boxes = 0;
          boxes_dropped = 1'b0;
        end
      end
      pending = heights_due.size();
    end
  end

endmodule

[tb/cuboid_stack_max_height_test.sv]
// ----------------------------------------------------------------------------
// cuboid_stack_max_height_test: testbench top for the cuboid stacking block
// Sends a short directed run of cuboid sets (extreme edges, rotations,
// nesting, reverse order, zero edges), then random sets of several edge
// styles, one set filling the store exactly and one overrunning it. The
// sender idles in bursts, the receiver stalls on its own pattern with two
// long holds; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module cuboid_stack_max_height_test import csmh_pkg::*; ();

  localparam int     MAX_BOXES     = DEF_MAX_BOXES;
  localparam int     DIM_BITS      = DEF_DIM_BITS;
  localparam int     ITEM_GOAL     = 750;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     LONG_HOLD     = 600;
  localparam longint RUN_LIMIT     = 40_000_000;

  localparam logic [DIM_BITS-1:0] EDGE_MAX = '1;

  typedef enum int {EDGE_FULL, EDGE_DENSE, EDGE_LAYERED, EDGE_CORNER, EDGE_TOP}
    edge_style_e;
  typedef enum int {TAKE_ALL, TAKE_RANDOM, TAKE_PATTERN} stall_e;

  logic   clk = 1'b0;
  logic   rst;
  int     pending;
  int     errors;
  int     items_sent;
  int     burst_left;
  int     gap_left;
  int     sets_done;
  int     results_taken;
  int     hold_left;
  int     stall_left;
  stall_e stall_mode;

  csmh_box_if #(.DIM_BITS(DIM_BITS)) boxes_ch ();
  csmh_res_if result_ch ();

  cuboid_stack_max_height #(
    .MAX_BOXES(MAX_BOXES),
    .DIM_BITS (DIM_BITS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .boxes (boxes_ch),
    .result(result_ch)
  );

  csmh_stack_checker #(
    .MAX_BOXES(MAX_BOXES),
    .DIM_BITS (DIM_BITS)
  ) u_checker (
    .clk    (clk),
    .rst    (rst),
    .boxes  (boxes_ch),
    .result (result_ch),
    .pending(pending),
    .errors (errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #RUN_LIMIT;
    $display("cuboid_stack_max_height test failed");
    $finish;
  end

  // Receiver: changing stall pattern, long holds after the 3rd and 30th item
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      results_taken = 0;
      hold_left = 0;
      stall_left = 0;
      stall_mode = TAKE_ALL;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_taken++;
        if (results_taken == 3 || results_taken == 30) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = stall_e'($urandom_range(0, 2));
          stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        case (stall_mode)
          TAKE_ALL:    result_ch.ready <= 1'b1;
          TAKE_RANDOM: result_ch.ready <= 1'($urandom_range(0, 1));
          default:     result_ch.ready <= (stall_left % 7) > 1;
        endcase
      end
    end
  end

  function automatic logic [DIM_BITS-1:0] pick_edge(input edge_style_e style,
                                                     input int level);
    logic [DIM_BITS-1:0] v;
    case (style)
      EDGE_DENSE:   v = DIM_BITS'($urandom_range(1, 12));
      EDGE_LAYERED: v = DIM_BITS'(level * 8 + $urandom_range(0, 11));
      EDGE_TOP:     v = EDGE_MAX;
      EDGE_CORNER: begin
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = DIM_BITS'(1);
          2:       v = EDGE_MAX;
          3:       v = EDGE_MAX - DIM_BITS'(1);
          4:       v = DIM_BITS'(1) << (DIM_BITS - 1);
          default: v = DIM_BITS'($urandom);
        endcase
      end
      default: v = ($urandom_range(0, 39) == 0) ? '0
                                                : DIM_BITS'($urandom_range(1, EDGE_MAX));
    endcase
    return v;
  endfunction

  // Offer one cuboid; start a new burst with a random gap when one runs out
  task automatic put_box(input logic [DIM_BITS-1:0] a, b, c, input logic is_last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = 60;
        gap_left = 0;
      end else begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      end
    end
    burst_left--;
    while (gap_left > 0) begin
      boxes_ch.valid <= 1'b0;
      @(posedge clk);
      gap_left--;
    end
    boxes_ch.valid <= 1'b1;
    boxes_ch.dim_a <= a;
    boxes_ch.dim_b <= b;
    boxes_ch.dim_c <= c;
    boxes_ch.last  <= is_last;
    do @(posedge clk); while (!boxes_ch.ready);
    items_sent++;
  endtask

  task automatic send_set(input int count, input edge_style_e style);
    int level;
    for (int k = 0; k < count; k++) begin
      level = $urandom_range(0, 120);
      put_box(pick_edge(style, level), pick_edge(style, level),
              pick_edge(style, level), k == count - 1);
    end
  endtask

  initial begin
    rst <= 1'b1;
    boxes_ch.valid <= 1'b0;
    boxes_ch.dim_a <= '0;
    boxes_ch.dim_b <= '0;
    boxes_ch.dim_c <= '0;
    boxes_ch.last  <= 1'b0;
    items_sent = 0;
    burst_left = 0;
    gap_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // single cuboids at the edge extremes, zero edges included
    put_box(1, 1, 1, 1'b1);
    put_box(EDGE_MAX, EDGE_MAX, EDGE_MAX, 1'b1);
    put_box(0, 0, 0, 1'b1);
    // rotations of one cuboid stack on each other
    put_box(3, 1, 2, 1'b0);
    put_box(2, 3, 1, 1'b0);
    put_box(1, 2, 3, 1'b1);
    // nesting through rotation
    put_box(5, 1, 1, 1'b0);
    put_box(1, 1, 6, 1'b1);
    // no nesting: the tallest single edge wins
    put_box(10, 1, 1, 1'b0);
    put_box(2, 2, 2, 1'b1);
    // mostly descending order: each insert after the first shifts entries up
    put_box(4, 4, 4, 1'b0);
    put_box(0, 7, 3, 1'b0);
    put_box(3, 3, 3, 1'b0);
    put_box(2, 2, 2, 1'b1);
    // alternating bit patterns
    put_box(10'h155, 10'h2AA, 10'h3FF, 1'b0);
    put_box(10'h2AA, 10'h155, 10'h000, 1'b1);

    sets_done = 0;
    while (items_sent < ITEM_GOAL) begin
      if (sets_done == 6) begin
        send_set(MAX_BOXES, EDGE_TOP);
      end else if (sets_done == 20) begin
        // overrun the store; the flagged cuboid itself is dropped
        send_set(MAX_BOXES + 2, EDGE_DENSE);
      end else begin
        send_set(($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                             : $urandom_range(1, 12),
                 edge_style_e'($urandom_range(0, 3)));
      end
      sets_done++;
      if (sets_done % 12 == 5) begin
        // hold input until every queued result is out
        boxes_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
    end

    boxes_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("cuboid_stack_max_height test passed");
    end else begin
      $display("cuboid_stack_max_height test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/csmh_pkg.sv
hw/rtl/csmh_box_if.sv
hw/rtl/csmh_res_if.sv
hw/rtl/csmh_ctrl.sv
hw/rtl/csmh_dp.sv
hw/rtl/cuboid_stack_max_height.sv
tb/csmh_stack_checker.sv
tb/cuboid_stack_max_height_test.sv
